/* design/assert_macros.svh */
// assertion helper macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* design/dbfd_pkg.sv */
// ---------------------------------------------------------------------------
// dbfd_pkg
// types and constants of the dual bus frame deduplicator
// ---------------------------------------------------------------------------
package dbfd_pkg;

  localparam int unsigned NumDevicesDef = 32;
  localparam int unsigned IdW           = 29;
  localparam int unsigned DataW         = 64;
  localparam int unsigned DevW          = 5;
  localparam int unsigned WinW          = 10;
  localparam int unsigned IdleW         = 16;
  localparam int unsigned KindW         = 3;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 16;

  localparam logic [WinW-1:0]  DupWindowRst = WinW'(30);
  localparam logic [IdleW-1:0] NoRxRst      = IdleW'(3000);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegDupWindow = 1'b0;
  localparam logic [CfgIdxW-1:0] RegNoRx      = 1'b1;

  // command codes
  localparam logic CmdFrame = 1'b0;
  localparam logic CmdTick  = 1'b1;

  // result kinds
  localparam logic [KindW-1:0] KindStatus  = 3'd0;
  localparam logic [KindW-1:0] KindForward = 3'd1;
  localparam logic [KindW-1:0] KindCopy    = 3'd2;
  localparam logic [KindW-1:0] KindRepeat  = 3'd3;
  localparam logic [KindW-1:0] KindTimeout = 3'd4;

  typedef enum logic [2:0] {
    StIdle,
    StLookup,
    StFrame,
    StScan,
    StEmit,
    StStatus
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic latch_in;     // capture the input beat
    logic frame_upd;    // classify and update for a frame
    logic scan_step;    // age the window of the current device
    logic scan_clr;     // zero the scan pointer
    logic scan_next;    // advance the scan pointer
    logic load_status;  // build the status result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic dev_ok;
    logic expired;      // current scan device expired this step
    logic scan_done;    // pointer on last device
  } stat_t;

endpackage

/* design/dbfd_ram.sv */
// ---------------------------------------------------------------------------
// dbfd_ram
// generic single port ram with registered read
// ---------------------------------------------------------------------------
module dbfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* design/dbfd_ctrl.sv */
// ---------------------------------------------------------------------------
// dbfd_ctrl
// sequencer for frame lookup and the per-tick device walk
// ---------------------------------------------------------------------------
module dbfd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic             out_free_i,
  input  dbfd_pkg::stat_t  stat_i,
  output dbfd_pkg::cmd_t   cmd_o,
  output logic             busy_o
);
  import dbfd_pkg::*;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_fire_i) state_d = StLookup;
      StLookup: begin
        if (stat_i.is_tick) state_d = StScan;
        else if (stat_i.dev_ok) state_d = StFrame;
        else state_d = StIdle;
      end
      StFrame:  if (out_free_i) state_d = StIdle;
      StScan:   begin
        if (stat_i.expired) state_d = StEmit;
        else if (stat_i.scan_done) state_d = StStatus;
      end
      StEmit:   if (out_free_i) state_d = stat_i.scan_done ? StStatus : StScan;
      StStatus: if (out_free_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    case (state_q)
      StIdle:   cmd_o.latch_in = in_fire_i;
      StLookup: cmd_o.scan_clr = 1'b1;
      StFrame:  cmd_o.frame_upd = out_free_i;
      StScan:   begin
        cmd_o.scan_step = ~stat_i.expired;
        cmd_o.scan_next = ~stat_i.expired & ~stat_i.scan_done;
      end
      StEmit:   begin
        cmd_o.scan_step = out_free_i;
        cmd_o.scan_next = out_free_i & ~stat_i.scan_done;
      end
      StStatus: cmd_o.load_status = out_free_i;
      default:  cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_one_upd, cmd_o.frame_upd, !cmd_o.scan_step && !cmd_o.load_status, clk_i, rst_ni)
  `ASSERT_IMPL(a_latch_idle, cmd_o.latch_in, state_q == StIdle, clk_i, rst_ni)
  `ASSERT_IMPL(a_emit_ret, state_q == StEmit && out_free_i, ##1 (state_q != StEmit), clk_i, rst_ni)
endmodule

/* design/dbfd_dp.sv */
// ---------------------------------------------------------------------------
// dbfd_dp
// per-device frame store, window tables, idle counters and result register
// ---------------------------------------------------------------------------
module dbfd_dp #(
  parameter int unsigned NumDevices = dbfd_pkg::NumDevicesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dbfd_pkg::cmd_t                 cmd_i,
  output dbfd_pkg::stat_t                stat_o,
  input  logic                           cfg_we_i,
  input  logic [dbfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dbfd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_fire_i,
  input  logic                           in_cmd_i,
  input  logic                           in_bus_i,
  input  logic [dbfd_pkg::DevW-1:0]      in_dev_i,
  input  logic [dbfd_pkg::IdW-1:0]       in_id_i,
  input  logic [dbfd_pkg::DataW-1:0]     in_data_i,
  input  logic                           out_take_i,
  output logic                           out_valid_o,
  output logic [dbfd_pkg::KindW-1:0]     out_kind_o,
  output logic [dbfd_pkg::IdW-1:0]       out_id_o,
  output logic [dbfd_pkg::DataW-1:0]     out_data_o,
  output logic [dbfd_pkg::DevW-1:0]      out_dev_o,
  output logic [1:0]                     out_err_o,
  output logic [1:0]                     out_silent_o,
  output logic                           out_last_o
);
  import dbfd_pkg::*;

  localparam int unsigned AddrW = (NumDevices > 1) ? $clog2(NumDevices) : 1;
  localparam int unsigned Depth = 1 << AddrW;
  localparam int unsigned EntW  = IdW + DataW;

  // configuration
  logic [WinW-1:0]  dup_win_q;
  logic [IdleW-1:0] no_rx_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dup_win_q <= DupWindowRst;
      no_rx_q   <= NoRxRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDupWindow: dup_win_q <= cfg_data_i[WinW-1:0];
        RegNoRx:      no_rx_q   <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // captured input beat
  logic             cmd_q, bus_q;
  logic [DevW-1:0]  dev_q;
  logic [IdW-1:0]   id_q;
  logic [DataW-1:0] data_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      cmd_q  <= in_cmd_i;
      bus_q  <= in_bus_i;
      dev_q  <= in_dev_i;
      id_q   <= in_id_i;
      data_q <= in_data_i;
    end
  end

  logic dev_ok;
  assign dev_ok = (32'(dev_q) < NumDevices);
  logic [AddrW-1:0] fdev;
  assign fdev = dev_q[AddrW-1:0];

  // frame store, one ram per bus
  logic [EntW-1:0] rd0, rd1;
  logic            we0, we1;
  assign we0 = cmd_i.frame_upd & ~bus_q;
  assign we1 = cmd_i.frame_upd &  bus_q;
  dbfd_ram #(.Width(EntW), .Depth(Depth)) u_seen0 (
    .clk_i, .we_i(we0), .addr_i(fdev), .wdata_i({id_q, data_q}), .rdata_o(rd0));
  dbfd_ram #(.Width(EntW), .Depth(Depth)) u_seen1 (
    .clk_i, .we_i(we1), .addr_i(fdev), .wdata_i({id_q, data_q}), .rdata_o(rd1));

  // per-device window state
  logic [1:0]      seen_q   [NumDevices];
  logic            wact_q   [NumDevices];
  logic            wbus_q   [NumDevices];
  logic [WinW-1:0] wel_q    [NumDevices];
  logic [1:0]      err_q    [NumDevices];
  logic [1:0]      idle_unused;
  logic [IdleW-1:0] idle_q [2];

  // scan pointer
  logic [AddrW-1:0] sp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sp_q <= '0;
    else if (cmd_i.scan_clr) sp_q <= '0;
    else if (cmd_i.scan_next) sp_q <= sp_q + 1'b1;
  end

  logic sp_exp;
  assign sp_exp = wact_q[sp_q] && (wel_q[sp_q] >= dup_win_q);
  logic [1:0] sp_err_new;
  assign sp_err_new = err_q[sp_q] | (wbus_q[sp_q] ? 2'b10 : 2'b01);

  // frame classification
  logic [1:0]  sv;
  logic        hit0, hit1, own_hit, oth_hit;
  assign sv   = seen_q[fdev];
  assign hit0 = sv[0] && (rd0 == {id_q, data_q});
  assign hit1 = sv[1] && (rd1 == {id_q, data_q});
  assign oth_hit = bus_q ? hit0 : hit1;
  assign own_hit = bus_q ? hit1 : hit0;
  logic [1:0] err_clr;
  assign err_clr = err_q[fdev] & ~(bus_q ? 2'b10 : 2'b01);

  assign idle_unused = '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDevices; i++) begin
        seen_q[i] <= '0;
        wact_q[i] <= 1'b0;
        wbus_q[i] <= 1'b0;
        wel_q[i]  <= '0;
        err_q[i]  <= '0;
      end
      idle_q[0] <= '0;
      idle_q[1] <= '0;
    end else begin
      // idle counters: a frame resets the counter of its bus, a tick ages both, saturating
      if (in_fire_i && in_cmd_i == CmdFrame) begin
        idle_q[in_bus_i] <= '0;
      end else if (in_fire_i && in_cmd_i == CmdTick) begin
        for (int b = 0; b < 2; b++)
          if (idle_q[b] != '1) idle_q[b] <= idle_q[b] + 1'b1;
      end
      if (cmd_i.frame_upd) begin
        if (oth_hit) begin
          seen_q[fdev][bus_q] <= 1'b1;
          wact_q[fdev] <= 1'b0;
          wel_q[fdev]  <= '0;
          err_q[fdev]  <= err_clr;
        end else if (!own_hit) begin
          seen_q[fdev][bus_q] <= 1'b1;
          wact_q[fdev] <= 1'b1;
          wbus_q[fdev] <= ~bus_q;
          wel_q[fdev]  <= '0;
        end
      end
      if (cmd_i.scan_step && wact_q[sp_q]) begin
        if (sp_exp) begin
          err_q[sp_q]  <= sp_err_new;
          wact_q[sp_q] <= 1'b0;
          wel_q[sp_q]  <= '0;
        end else begin
          wel_q[sp_q] <= wel_q[sp_q] + 1'b1;
        end
      end
    end
  end

  logic [1:0] silent;
  assign silent[0] = idle_q[0] > no_rx_q;
  assign silent[1] = idle_q[1] > no_rx_q;

  // result register
  logic load_frame, load_exp;
  assign load_frame = cmd_i.frame_upd;
  assign load_exp   = cmd_i.scan_step & sp_exp;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (load_frame || load_exp || cmd_i.load_status) out_valid_o <= 1'b1;
    else if (out_take_i) out_valid_o <= 1'b0;
  end
  // silence flags are captured with the result so later beats cannot alter it
  always_ff @(posedge clk_i) begin
    if (load_frame) begin
      out_kind_o   <= oth_hit ? KindCopy : (own_hit ? KindRepeat : KindForward);
      out_id_o     <= id_q;
      out_data_o   <= data_q;
      out_dev_o    <= dev_q;
      out_err_o    <= oth_hit ? err_clr : err_q[fdev];
      out_silent_o <= silent;
      out_last_o   <= 1'b1;
    end else if (load_exp) begin
      out_kind_o   <= KindTimeout;
      out_id_o     <= '0;
      out_data_o   <= '0;
      out_dev_o    <= DevW'(sp_q);
      out_err_o    <= sp_err_new;
      out_silent_o <= silent;
      out_last_o   <= 1'b0;
    end else if (cmd_i.load_status) begin
      out_kind_o   <= KindStatus;
      out_id_o     <= '0;
      out_data_o   <= '0;
      out_dev_o    <= '0;
      out_err_o    <= idle_unused;
      out_silent_o <= silent;
      out_last_o   <= 1'b1;
    end
  end

  assign stat_o.is_tick   = (cmd_q == CmdTick);
  assign stat_o.dev_ok    = dev_ok;
  assign stat_o.expired   = sp_exp;
  assign stat_o.scan_done = (32'(sp_q) == NumDevices - 1);

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_double_load, load_frame, !load_exp && !cmd_i.load_status, clk_i, rst_ni)
  `ASSERT_IMPL(a_exp_active, load_exp, wact_q[sp_q], clk_i, rst_ni)
  `ASSERT_IMPL(a_load_free, load_exp || load_frame, !out_valid_o || out_take_i, clk_i, rst_ni)
endmodule

/* design/dual_bus_frame_dedup.sv */
// ---------------------------------------------------------------------------
// dual_bus_frame_dedup
// merges frames from two redundant buses, drops repeats, tracks copy windows
// ---------------------------------------------------------------------------
// a frame's result is loaded after the lookup (store read) and frame (compare) states
// a tick walks one device per cycle, set by the single scan pointer, but pauses
// to emit each expired window; the status result follows the last device
// one item is in work at a time; the next beat is taken the cycle after the last
// result is loaded, and output stalls hold the frame, emit and status states
// reset clears windows, error masks, seen flags, idle counters; config to defaults
module dual_bus_frame_dedup #(
  parameter int unsigned NUM_DEVICES = dbfd_pkg::NumDevicesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tuser,  // command, bus
  input  logic [103:0] s_axis_tdata,  // device[4:0], frame_id[33:5], payload[97:34]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tuser,  // kind[2:0]
  output logic [103:0] m_axis_tdata,  // out_id, out_payload, out_device, device_error, bus_silent
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [0:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);
  import dbfd_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy, in_fire, out_take, out_free;
  logic [IdW-1:0]   oid;
  logic [DataW-1:0] odata;
  logic [DevW-1:0]  odev;
  logic [1:0]       oerr, osil;
  logic [KindW-1:0] okind;

  assign s_axis_tready = ~busy;
  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_take = m_axis_tvalid & m_axis_tready;
  assign out_free = ~m_axis_tvalid | m_axis_tready;
  assign cfg_ready_o = 1'b1;

  dbfd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_free_i(out_free),
    .stat_i(stat), .cmd_o(cmd), .busy_o(busy));

  dbfd_dp #(.NumDevices(NUM_DEVICES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_fire_i(in_fire), .in_cmd_i(s_axis_tuser[0]), .in_bus_i(s_axis_tuser[1]),
    .in_dev_i(s_axis_tdata[4:0]), .in_id_i(s_axis_tdata[33:5]),
    .in_data_i(s_axis_tdata[97:34]), .out_take_i(out_take),
    .out_valid_o(m_axis_tvalid), .out_kind_o(okind), .out_id_o(oid),
    .out_data_o(odata), .out_dev_o(odev), .out_err_o(oerr),
    .out_silent_o(osil), .out_last_o(m_axis_tlast));

  assign m_axis_tuser = {5'd0, okind};
  assign m_axis_tdata = {2'd0, osil, oerr, odev, odata, oid};
endmodule
